// ===== hw/rtl/psbc_pkg.sv =====
// shared types and constants for the page sprite byte compositor
package psbc_pkg;

   localparam int unsigned STORE_DEPTH_DEFAULT = 1024;
   // frame * width * height + row offset + column stays below 2**20
   localparam int unsigned SADDR_W = 20;
   localparam int unsigned LOAD_ADDR_W = 10;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_COMPOSE = 1'b1
   } psbc_cmd_type;

   typedef enum logic {
      REG_SPRITE_WIDTH  = 1'b0,
      REG_SPRITE_HEIGHT = 1'b1
   } psbc_reg_type;

   typedef struct packed {
      logic [7:0]  width;
      logic [3:0]  height;
      logic [11:0] cells;
   } psbc_cfg_type;

   typedef struct packed {
      logic               is_load;
      logic [SADDR_W-1:0] load_addr;
      logic [7:0]         load_data;
      logic [7:0]         dx;
      logic [3:0]         line;
      logic [2:0]         off;
      logic [7:0]         frame;
      logic               cur_ok;
      logic               prev_ok;
   } psbc_item_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } psbc_queue_stat_type;

   typedef struct packed {
      logic pop;
      logic stall;
   } psbc_back_stat_type;

endpackage

// ===== hw/rtl/psbc_chan_if.sv =====
// request and response channel interfaces
interface psbc_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [9:0]        load_address;
   logic [7:0]        load_data;
   logic signed [7:0] sprite_x;
   logic signed [7:0] sprite_y;
   logic [6:0]        column;
   logic [2:0]        page;
   logic [7:0]        frame;

   modport source (
      output valid, command, load_address, load_data, sprite_x, sprite_y,
             column, page, frame,
      input  ready
   );
   modport sink (
      input  valid, command, load_address, load_data, sprite_x, sprite_y,
             column, page, frame,
      output ready
   );
endinterface

interface psbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, pixel_byte, input ready);
   modport sink (input valid, pixel_byte, output ready);
endinterface

// ===== hw/rtl/psbc_front.sv =====
// front end: takes request transfers and classifies them against the sprite box
module psbc_front (
   psbc_req_if.sink             req_ch,
   input  psbc_pkg::psbc_cfg_type  cfg,
   input  logic                    q_full,
   output logic                    push,
   output psbc_pkg::psbc_item_type item
);
   import psbc_pkg::*;

   logic signed [9:0] dx;
   logic signed [4:0] top;
   logic signed [5:0] line;
   logic              in_box;
   logic              below_h;

   assign req_ch.ready = !q_full;
   assign push = req_ch.valid && !q_full;

   always_comb begin
      dx = $signed({3'b000, req_ch.column}) - 10'(req_ch.sprite_x);
      // floor of sprite_y / 8
      top = 5'(req_ch.sprite_y >>> 3);
      line = $signed({3'b000, req_ch.page}) - 6'(top);
      in_box = (dx >= 10'sd0) && (dx < $signed({2'b00, cfg.width}))
               && (line >= 6'sd0) && (line <= $signed({2'b00, cfg.height}));
      below_h = line < $signed({2'b00, cfg.height});

      item.is_load   = (psbc_cmd_type'(req_ch.command) == CMD_LOAD);
      item.load_addr = SADDR_W'(req_ch.load_address);
      item.load_data = req_ch.load_data;
      item.dx        = dx[7:0];
      item.line      = line[3:0];
      item.off       = req_ch.sprite_y[2:0];
      item.frame     = req_ch.frame;
      // spill page shows only the bottom row
      item.cur_ok    = in_box && below_h;
      item.prev_ok   = in_box && (line != 6'sd0) && (req_ch.sprite_y[2:0] != 3'd0);
   end

endmodule

// ===== hw/rtl/psbc_queue.sv =====
// short queue between the front end and the back end
module psbc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  psbc_pkg::psbc_item_type      item_in,
   input  logic                         pop,
   output psbc_pkg::psbc_item_type      item_out,
   output psbc_pkg::psbc_queue_stat_type stat
);
   import psbc_pkg::*;

   psbc_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign item_out   = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// ===== hw/rtl/psbc_back.sv =====
// back end: address pipeline, sprite store and byte composition
module psbc_back #(
   parameter int unsigned STORE_DEPTH = psbc_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psbc_pkg::psbc_cfg_type       cfg,
   input  psbc_pkg::psbc_queue_stat_type q_stat,
   input  psbc_pkg::psbc_item_type      q_item,
   output psbc_pkg::psbc_back_stat_type stat,
   psbc_rsp_if.source                   rsp_ch
);
   import psbc_pkg::*;

   localparam int unsigned AW = $clog2(STORE_DEPTH);

   logic en;
   logic pop;

   // stage 1: products
   logic               s1_valid_ff;
   psbc_item_type      s1_item_ff;
   logic [SADDR_W-1:0] s1_base_ff, s1_base_in;
   logic [11:0]        s1_rowcur_ff, s1_rowcur_in;
   logic [11:0]        s1_rowprev_ff, s1_rowprev_in;
   logic [3:0]         line_m1;

   // stage 2: store addresses
   logic               s2_valid_ff;
   logic               s2_is_load_ff;
   logic [7:0]         s2_data_ff;
   logic [2:0]         s2_off_ff;
   logic               s2_cur_ok_ff;
   logic               s2_prev_ok_ff;
   logic [SADDR_W-1:0] s2_addr_cur_ff, s2_addr_cur_in;
   logic [SADDR_W-1:0] s2_addr_prev_ff, s2_addr_prev_in;

   // stage 3: store read
   logic               cur_range;
   logic               prev_range;
   logic [7:0]         store_mem [STORE_DEPTH];
   logic               s3_valid_ff;
   logic [2:0]         s3_off_ff;
   logic               s3_cur_use_ff;
   logic               s3_prev_use_ff;
   logic [7:0]         rd_cur_ff;
   logic [7:0]         rd_prev_ff;

   // stage 4: result
   logic               rsp_valid_ff;
   logic [7:0]         pixel_ff, pixel_in;

   assign en  = !rsp_valid_ff || rsp_ch.ready;
   assign pop = en && !q_stat.empty;

   assign stat.pop   = pop;
   assign stat.stall = !en;

   always_comb begin
      line_m1        = (q_item.line == 4'd0) ? 4'd0 : q_item.line - 4'd1;
      s1_base_in     = SADDR_W'(q_item.frame) * SADDR_W'(cfg.cells);
      s1_rowcur_in   = 12'(q_item.line) * 12'(cfg.width);
      s1_rowprev_in  = 12'(line_m1) * 12'(cfg.width);

      s2_addr_cur_in  = s1_item_ff.is_load ? s1_item_ff.load_addr
                        : s1_base_ff + SADDR_W'(s1_rowcur_ff) + SADDR_W'(s1_item_ff.dx);
      s2_addr_prev_in = s1_base_ff + SADDR_W'(s1_rowprev_ff) + SADDR_W'(s1_item_ff.dx);

      cur_range  = s2_addr_cur_ff < SADDR_W'(STORE_DEPTH);
      prev_range = s2_addr_prev_ff < SADDR_W'(STORE_DEPTH);

      pixel_in = 8'd0;
      if (s3_cur_use_ff) begin
         pixel_in = 8'(rd_cur_ff << s3_off_ff);
      end
      if (s3_prev_use_ff) begin
         pixel_in = pixel_in | 8'(rd_prev_ff >> (4'd8 - 4'(s3_off_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && !s2_is_load_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff      <= q_item;
         s1_base_ff      <= s1_base_in;
         s1_rowcur_ff    <= s1_rowcur_in;
         s1_rowprev_ff   <= s1_rowprev_in;

         s2_is_load_ff   <= s1_item_ff.is_load;
         s2_data_ff      <= s1_item_ff.load_data;
         s2_off_ff       <= s1_item_ff.off;
         s2_cur_ok_ff    <= s1_item_ff.cur_ok;
         s2_prev_ok_ff   <= s1_item_ff.prev_ok;
         s2_addr_cur_ff  <= s2_addr_cur_in;
         s2_addr_prev_ff <= s2_addr_prev_in;

         s3_off_ff       <= s2_off_ff;
         s3_cur_use_ff   <= s2_cur_ok_ff && cur_range;
         s3_prev_use_ff  <= s2_prev_ok_ff && prev_range;

         pixel_ff        <= pixel_in;
      end
   end

   // loads and reads meet the store in the same stage, so program order holds
   always_ff @(posedge clock) begin
      if (en && s2_valid_ff && s2_is_load_ff && cur_range) begin
         store_mem[s2_addr_cur_ff[AW-1:0]] <= s2_data_ff;
      end
      if (en) begin
         rd_cur_ff  <= store_mem[s2_addr_cur_ff[AW-1:0]];
         rd_prev_ff <= store_mem[s2_addr_prev_ff[AW-1:0]];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_byte = pixel_ff;

endmodule

// ===== hw/rtl/page_sprite_byte_compositor.sv =====
// top level: register port, front end, queue and back end of the sprite compositor
// a compose result is registered in the queue, then in the products, store address, store read and result stages
// throughput: one item per cycle; the back end stalls only while a result waits on rsp_ch.ready
// loads give no result; the store has one write and two read ports, read data registered
// reset: synchronous, clears valid and queue state, sprite_width 8, sprite_height_pages 1
// reset leaves the sprite store contents undefined; no clearing pass is run
module page_sprite_byte_compositor #(
   parameter int unsigned SPRITE_STORE_DEPTH = psbc_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   psbc_req_if.sink                          req_ch,
   psbc_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [psbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [psbc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [psbc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import psbc_pkg::*;

   logic [7:0]  width_ff, width_in;
   logic [3:0]  height_ff, height_in;
   logic [11:0] cells_ff, cells_in;
   logic        csr_wr;
   psbc_reg_type csr_idx;
   psbc_cfg_type cfg;

   logic                push;
   psbc_item_type       front_item;
   psbc_item_type       q_item;
   psbc_queue_stat_type q_stat;
   psbc_back_stat_type  back_stat;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = psbc_reg_type'(paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SPRITE_WIDTH:  width_in  = pwdata[7:0];
            REG_SPRITE_HEIGHT: height_in = pwdata[3:0];
            default: ;
         endcase
      end
      // cell count kept ready so the back end forms the frame base with a single product
      cells_in = 12'(width_in) * 12'(height_in);
   end

   always_comb begin
      case (csr_idx)
         REG_SPRITE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_SPRITE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd8;
         height_ff <= 4'd1;
         cells_ff  <= 12'd8;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         cells_ff  <= cells_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.cells  = cells_ff;

   psbc_front u_front (
      .req_ch (req_ch),
      .cfg    (cfg),
      .q_full (q_stat.full),
      .push   (push),
      .item   (front_item)
   );

   psbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (back_stat.pop),
      .item_out (q_item),
      .stat     (q_stat)
   );

   psbc_back #(
      .STORE_DEPTH (SPRITE_STORE_DEPTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .q_stat (q_stat),
      .q_item (q_item),
      .stat   (back_stat),
      .rsp_ch (rsp_ch)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy past its depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_stat.empty)
      else $error("accepted transfer did not land in the queue");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> (back_stat.stall && !back_stat.pop))
      else $error("back end advanced while a result waits");

   a_cells_track: assert property (@(posedge clock) disable iff (reset)
      cells_ff == 12'(width_ff) * 12'(height_ff))
      else $error("cell count out of step with size registers");

endmodule

// ===== test/page_sprite_byte_compositor_tb.sv =====
// self-checking bench for the page sprite byte compositor: store loads, composes, size registers
`timescale 1ns / 100ps

module page_sprite_byte_compositor_tb;
   import psbc_pkg::*;

   localparam int STORE_DEPTH = STORE_DEPTH_DEFAULT;
   localparam int PHASES = 9;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      psbc_cmd_type      command;
      logic [9:0]        load_address;
      logic [7:0]        load_data;
      logic signed [7:0] sprite_x;
      logic signed [7:0] sprite_y;
      logic [6:0]        column;
      logic [2:0]        page;
      logic [7:0]        frame;
   } sprite_req_type;

   class sprite_scoreboard;
      bit [7:0] store [STORE_DEPTH];
      int       width_reg = 8;
      int       height_reg = 1;
      bit [7:0] expected_bytes [$];
      int       mismatches;
      int       loads_seen;
      int       bytes_checked;

      function void set_register(psbc_reg_type idx, int unsigned value);
         if (idx == REG_SPRITE_WIDTH) begin
            width_reg = int'(value & 32'hFF);
         end else begin
            height_reg = int'(value & 32'hF);
         end
      endfunction

      function int register_value(psbc_reg_type idx);
         return (idx == REG_SPRITE_WIDTH) ? width_reg : height_reg;
      endfunction

      function bit [7:0] read_store(int addr);
         return (addr < STORE_DEPTH) ? store[addr] : 8'h00;
      endfunction

      function bit [7:0] compose_byte(sprite_req_type r);
         int       sx, sy, top, dx, line, off, cells, base, a;
         bit [7:0] pix;
         sx = r.sprite_x;
         sy = r.sprite_y;
         top = sy >>> 3;
         off = int'(r.sprite_y[2:0]);
         dx = int'(r.column) - sx;
         line = int'(r.page) - top;
         pix = 8'h00;
         if (dx >= 0 && dx < width_reg && line >= 0 && line <= height_reg) begin
            cells = width_reg * height_reg;
            base = int'(r.frame) * cells;
            a = dx + line * width_reg;
            // on the spill page a stays past the frame, so only the row above shows
            if (a < cells) begin
               pix = read_store(base + a) << off;
            end
            if (line > 0 && off != 0) begin
               a = dx + (line - 1) * width_reg;
               if (a < cells) begin
                  pix |= read_store(base + a) >> (8 - off);
               end
            end
         end
         return pix;
      endfunction

      function void note_request(sprite_req_type r);
         if (r.command == CMD_LOAD) begin
            if (int'(r.load_address) < STORE_DEPTH) begin
               store[r.load_address] = r.load_data;
            end
            loads_seen++;
         end else begin
            expected_bytes.push_back(compose_byte(r));
         end
      endfunction

      function void check_pixel(logic [7:0] actual);
         bit [7:0] want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: pixel_byte %02h with no compose pending, expected none", $time,
                     actual);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (actual !== want) begin
               $display("%0t: pixel_byte mismatch: expected %02h, actual %02h", $time, want,
                        actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   psbc_req_if req_ch ();
   psbc_rsp_if rsp_ch ();

   sprite_scoreboard board = new;

   int send_gap_max = 7;
   int take_stall_max = 7;
   bit hold_request;
   int cycle_count;

   int phase_width [PHASES] = '{8, 1, 128, 255, 0, 6, 16, 3, 0};
   int phase_height [PHASES] = '{1, 1, 8, 15, 4, 0, 2, 8, 0};

   page_sprite_byte_compositor #(
      .SPRITE_STORE_DEPTH(STORE_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d composed bytes still awaited", board.expected_bytes.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic sprite_req_type random_fields();
      sprite_req_type r;
      r.command = ($urandom_range(0, 1) != 0) ? CMD_COMPOSE : CMD_LOAD;
      r.load_address = 10'($urandom);
      r.load_data = 8'($urandom);
      r.sprite_x = 8'($urandom);
      r.sprite_y = 8'($urandom);
      r.column = 7'($urandom);
      r.page = 3'($urandom);
      r.frame = 8'($urandom);
      return r;
   endfunction

   function automatic sprite_req_type load_req(int addr, int data);
      sprite_req_type r;
      r = random_fields();
      r.command = CMD_LOAD;
      r.load_address = 10'(addr);
      r.load_data = 8'(data);
      return r;
   endfunction

   function automatic sprite_req_type compose_req(int sx, int sy, int col, int pg, int frame);
      sprite_req_type r;
      r = random_fields();
      r.command = CMD_COMPOSE;
      r.sprite_x = 8'(sx);
      r.sprite_y = 8'(sy);
      r.column = 7'(col);
      r.page = 3'(pg);
      r.frame = 8'(frame);
      return r;
   endfunction

   // mostly aims the column and page at the sprite or one step around it
   function automatic sprite_req_type random_compose(int w, int h);
      sprite_req_type r;
      int             dx, line, sx, sy, cells, last_frame;
      r = random_fields();
      r.command = CMD_COMPOSE;
      if ($urandom_range(0, 9) != 0) begin
         dx = int'($urandom_range(0, w + 1)) - 1;
         sx = int'(r.column) - dx;
         if (sx >= -128 && sx <= 127) begin
            r.sprite_x = 8'(sx);
         end
         line = int'($urandom_range(0, h + 2)) - 1;
         sy = (int'(r.page) - line) * 8 + int'($urandom_range(0, 7));
         if (sy >= -128 && sy <= 127) begin
            r.sprite_y = 8'(sy);
         end
         cells = w * h;
         if (cells != 0) begin
            last_frame = (STORE_DEPTH + cells - 1) / cells;
            r.frame = 8'($urandom_range(0, (last_frame < 255) ? last_frame : 255));
         end
      end
      return r;
   endfunction

   task automatic send_req(input sprite_req_type r);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.command <= r.command;
      req_ch.load_address <= r.load_address;
      req_ch.load_data <= r.load_data;
      req_ch.sprite_x <= r.sprite_x;
      req_ch.sprite_y <= r.sprite_y;
      req_ch.column <= r.column;
      req_ch.page <= r.page;
      req_ch.frame <= r.frame;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (board.expected_bytes.size() != 0) @(posedge clock);
      // loads give no result and may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input psbc_reg_type idx, input int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic csr_read_check(input psbc_reg_type idx);
      logic [CSR_DATA_W-1:0] got;
      logic [CSR_DATA_W-1:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      want = CSR_DATA_W'(board.register_value(idx));
      if (got !== want) begin
         $display("%0t: %s readback mismatch: expected %0h, actual %0h", $time, idx.name(),
                  want, got);
         board.mismatches++;
      end
   endtask

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = $urandom_range(0, take_stall_max);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         board.check_pixel(rsp_ch.pixel_byte);
      end
   end

   initial begin
      int w, h;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOAD;
      req_ch.load_address = '0;
      req_ch.load_data = '0;
      req_ch.sprite_x = '0;
      req_ch.sprite_y = '0;
      req_ch.column = '0;
      req_ch.page = '0;
      req_ch.frame = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check(REG_SPRITE_WIDTH);
      csr_read_check(REG_SPRITE_HEIGHT);

      // every entry is written before any compose can read it
      for (int addr = 0; addr < STORE_DEPTH; addr++) begin
         send_req(load_req(addr, $urandom_range(0, 255)));
      end

      // reset size: 8 columns by 1 page, 8 bytes per frame
      send_req(compose_req(0, 0, 0, 0, 0));
      send_req(compose_req(0, 0, 7, 0, 0));
      send_req(compose_req(0, 0, 8, 0, 0));
      send_req(compose_req(-128, 0, 0, 0, 0));
      send_req(compose_req(127, 0, 127, 0, 3));
      send_req(compose_req(-3, 0, 0, 0, 1));
      send_req(compose_req(0, -128, 0, 0, 0));
      send_req(compose_req(0, 127, 0, 7, 0));
      send_req(compose_req(0, -3, 2, 0, 0));
      send_req(compose_req(0, 3, 2, 0, 0));
      send_req(compose_req(0, 3, 2, 1, 0));
      send_req(compose_req(0, 3, 2, 2, 0));
      send_req(compose_req(0, 8, 2, 0, 0));
      send_req(compose_req(0, 8, 2, 1, 4));
      send_req(compose_req(0, 0, 5, 0, 127));
      send_req(compose_req(0, 0, 5, 0, 128));
      send_req(compose_req(0, 0, 5, 0, 255));
      // compose right behind the load of the byte it reads
      send_req(load_req(0, 8'hFF));
      send_req(compose_req(0, 4, 0, 0, 0));
      send_req(load_req(1023, 8'h00));
      send_req(compose_req(0, 0, 7, 0, 127));
      send_req(load_req(513, 8'h5A));
      send_req(compose_req(8, 2, 9, 0, 64));

      for (int p = 0; p < PHASES; p++) begin
         w = phase_width[p];
         h = phase_height[p];
         if (p == PHASES - 1) begin
            w = $urandom_range(1, 128);
            h = $urandom_range(1, 8);
         end
         wait_idle();
         csr_write(REG_SPRITE_WIDTH, w);
         csr_write(REG_SPRITE_HEIGHT, h);
         csr_read_check(REG_SPRITE_WIDTH);
         csr_read_check(REG_SPRITE_HEIGHT);
         case (p % 3)
            0: begin
               send_gap_max = 7;
               take_stall_max = 7;
            end
            1: begin
               send_gap_max = 0;
               take_stall_max = 0;
            end
            default: begin
               send_gap_max = 0;
               take_stall_max = 7;
               hold_request = 1'b1;
            end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               send_req(load_req($urandom_range(0, 1023), $urandom_range(0, 255)));
            end else begin
               send_req(random_compose(w, h));
            end
         end
      end

      wait_idle();
      $display("covered %0d store loads and %0d composed bytes over %0d size settings,",
               board.loads_seen, board.bytes_checked, PHASES + 1);
      $display("with zero and oversize sprites, spill pages and reads past the store depth");
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
